FILE: design/sm4_pkg.sv
// shared types, constants and round functions for the sm4 block cipher core
package sm4_pkg;

    // round count and round key store geometry
    localparam int ROUNDS = 32;
    localparam int RK_AW  = $clog2(ROUNDS);

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_HIGH     = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW      = 2'd1;
    localparam logic [1:0] CFG_DECRYPT_MODE = 2'd2;

    // system parameter fk
    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    // input word: one 128-bit block
    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } data_word_t;

    // result word: one 128-bit block
    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } result_word_t;

    // write port of the round key store
    typedef struct packed {
        logic             en;
        logic [RK_AW-1:0] addr;
        logic [31:0]      data;
    } rk_wr_t;

    // key schedule sequencer states
    typedef enum logic [1:0] {
        KS_IDLE,
        KS_LOAD,
        KS_RUN
    } ks_state_t;

    // round datapath states
    typedef enum logic {
        CORE_IDLE,
        CORE_RUN
    } core_state_t;

    // s-box
    localparam logic [7:0] SBOX_TABLE [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // byte-wise s-box substitution
    function automatic logic [31:0] tau(input logic [31:0] a);
        return {SBOX_TABLE[a[31:24]], SBOX_TABLE[a[23:16]],
                SBOX_TABLE[a[15:8]],  SBOX_TABLE[a[7:0]]};
    endfunction

    // linear transform of the data rounds
    function automatic logic [31:0] lin_data(input logic [31:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // linear transform of the key schedule
    function automatic logic [31:0] lin_key(input logic [31:0] b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // ck constant: byte j of word i is (4i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
        logic [31:0] w;
        logic [7:0]  base;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            base = {1'b0, i, 2'(j)};
            w = {w[23:0], 8'(base * 8'd7)};
        end
        return w;
    endfunction

endpackage

FILE: design/sm4_rk_mem.sv
// round key store: 32 x 32 synchronous memory, one write and one registered read port
module sm4_rk_mem
    import sm4_pkg::*;
(
    input  logic             clk,
    input  rk_wr_t           wr,
    input  logic [RK_AW-1:0] rd_addr,
    output logic [31:0]      rd_data
);

    logic [31:0] mem [ROUNDS];
    logic [31:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/sm4_key_sched.sv
// configuration registers and key expansion sequencer that fills the round key store
module sm4_key_sched
    import sm4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output rk_wr_t      wr,
    output logic        busy
);

    ks_state_t        state_reg, state_next;
    logic [63:0]      key_high_reg;
    logic [63:0]      key_low_reg;
    logic             decrypt_mode_reg;
    logic [RK_AW-1:0] cnt_reg;
    logic [31:0]      k_reg [4];
    logic             cfg_hit;
    logic [31:0]      rk;

    // register index decode
    always_comb
    begin
        unique case (cfg_index) inside
            CFG_KEY_HIGH, CFG_KEY_LOW, CFG_DECRYPT_MODE: cfg_hit = cfg_we;
            default:                                     cfg_hit = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg     <= '0;
            key_low_reg      <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_HIGH:     key_high_reg     <= cfg_data;
                CFG_KEY_LOW:      key_low_reg      <= cfg_data;
                CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // next state: any register write restarts the expansion
    always_comb
    begin
        state_next = state_reg;
        if (cfg_hit)
        begin
            state_next = KS_LOAD;
        end
        else
        begin
            unique case (state_reg)
                KS_IDLE: state_next = KS_IDLE;
                KS_LOAD: state_next = KS_RUN;
                KS_RUN:
                begin
                    if (cnt_reg == RK_AW'(ROUNDS - 1))
                    begin
                        state_next = KS_IDLE;
                    end
                end
                default: state_next = KS_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // one key schedule round
    assign rk = k_reg[0] ^ lin_key(tau(k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ ck_word(cnt_reg)));

    // outputs: store write and busy
    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = cnt_reg;
        wr.data = rk;
        busy    = cfg_hit;
        unique case (state_reg)
            KS_IDLE: ;
            KS_LOAD: busy = 1'b1;
            KS_RUN:
            begin
                busy  = 1'b1;
                wr.en = 1'b1;
                if (decrypt_mode_reg)
                begin
                    wr.addr = RK_AW'(ROUNDS - 1) - cnt_reg;
                end
            end
            default: ;
        endcase
    end

    // key word shift register and round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == KS_LOAD)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == KS_RUN)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == KS_LOAD)
        begin
            k_reg[0] <= FK0 ^ key_high_reg[63:32];
            k_reg[1] <= FK1 ^ key_high_reg[31:0];
            k_reg[2] <= FK2 ^ key_low_reg[63:32];
            k_reg[3] <= FK3 ^ key_low_reg[31:0];
        end
        else if (state_reg == KS_RUN)
        begin
            k_reg[0] <= k_reg[1];
            k_reg[1] <= k_reg[2];
            k_reg[2] <= k_reg[3];
            k_reg[3] <= rk;
        end
    end

endmodule

FILE: design/sm4_round_core.sv
// data round sequencer: one round per cycle, round key read from the store
module sm4_round_core
    import sm4_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  data_word_t       data_word,
    input  logic [31:0]      rk_data,
    output logic [RK_AW-1:0] rk_addr,
    output logic             busy,
    output logic             done,
    output result_word_t     result_word
);

    core_state_t      state_reg, state_next;
    logic [RK_AW-1:0] cnt_reg;
    logic [31:0]      x_reg [4];
    logic             done_reg;
    result_word_t     result_reg;
    logic             last_round;
    logic [31:0]      t;

    assign last_round = (cnt_reg == RK_AW'(ROUNDS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (accept)
                begin
                    state_next = CORE_RUN;
                end
            end
            CORE_RUN:
            begin
                if (last_round)
                begin
                    state_next = CORE_IDLE;
                end
            end
            default: state_next = CORE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs: busy and round key address, one round ahead
    always_comb
    begin
        busy    = 1'b0;
        rk_addr = '0;
        unique case (state_reg)
            CORE_IDLE: ;
            CORE_RUN:
            begin
                busy    = 1'b1;
                rk_addr = cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // one data round
    assign t = x_reg[0] ^ lin_data(tau(x_reg[1] ^ x_reg[2] ^ x_reg[3] ^ rk_data));

    // round counter and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == CORE_RUN) && last_round;
            if (state_reg == CORE_RUN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // block state words and result register
    always_ff @(posedge clk)
    begin
        if (state_reg == CORE_IDLE && accept)
        begin
            x_reg[0] <= data_word.block_high[63:32];
            x_reg[1] <= data_word.block_high[31:0];
            x_reg[2] <= data_word.block_low[63:32];
            x_reg[3] <= data_word.block_low[31:0];
        end
        else if (state_reg == CORE_RUN)
        begin
            x_reg[0] <= x_reg[1];
            x_reg[1] <= x_reg[2];
            x_reg[2] <= x_reg[3];
            x_reg[3] <= t;
            if (last_round)
            begin
                result_reg.result_high <= {t, x_reg[3]};
                result_reg.result_low  <= {x_reg[2], x_reg[1]};
            end
        end
    end

    assign done        = done_reg;
    assign result_word = result_reg;

endmodule

FILE: design/sm4_block_cipher_core.sv
// top level of the sm4 ecb block cipher core
// the result strobe is registered from the last data round of the taken input word
// a new word is taken only after the last round of the previous one through the shared round unit
// a key or mode write runs key expansion, with busy high meanwhile
// reset clears the key, the mode and all control state; round keys are valid after a write
// results are shown for one cycle on done; the receiver cannot stall
module sm4_block_cipher_core
    import sm4_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  data_word_t   data_word,
    output logic         done,
    output result_word_t result_word,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    rk_wr_t           rk_wr;
    logic [RK_AW-1:0] rk_addr;
    logic [31:0]      rk_data;
    logic             ks_busy;
    logic             core_busy;
    logic             accept;

    // input word acceptance
    assign busy   = ks_busy | core_busy;
    assign accept = start && !busy;

    sm4_key_sched u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr        (rk_wr),
        .busy      (ks_busy)
    );

    sm4_rk_mem u_rk_mem (
        .clk     (clk),
        .wr      (rk_wr),
        .rd_addr (rk_addr),
        .rd_data (rk_data)
    );

    sm4_round_core u_round_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_word   (data_word),
        .rk_data     (rk_data),
        .rk_addr     (rk_addr),
        .busy        (core_busy),
        .done        (done),
        .result_word (result_word)
    );

endmodule

FILE: design/sm4_core_chk.sv
// port-level checker for the sm4 block cipher core and its bind
module sm4_core_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // an accepted word makes the core busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting a word");

    // no result right after an accept
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe right after accept");

    // a result is only produced after the core was working
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

endmodule

bind sm4_block_cipher_core sm4_core_chk u_sm4_core_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

FILE: dv/tb_sm4_block_cipher_core.sv
// self-checking testbench for the sm4 ecb block cipher core
module tb_sm4_block_cipher_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sm4_pkg::*;

    // register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // standard sm4 s-box
    localparam bit [7:0] SBOX_LUT [256] = '{
        'hd6,'h90,'he9,'hfe,'hcc,'he1,'h3d,'hb7,'h16,'hb6,'h14,'hc2,'h28,'hfb,'h2c,'h05,
        'h2b,'h67,'h9a,'h76,'h2a,'hbe,'h04,'hc3,'haa,'h44,'h13,'h26,'h49,'h86,'h06,'h99,
        'h9c,'h42,'h50,'hf4,'h91,'hef,'h98,'h7a,'h33,'h54,'h0b,'h43,'hed,'hcf,'hac,'h62,
        'he4,'hb3,'h1c,'ha9,'hc9,'h08,'he8,'h95,'h80,'hdf,'h94,'hfa,'h75,'h8f,'h3f,'ha6,
        'h47,'h07,'ha7,'hfc,'hf3,'h73,'h17,'hba,'h83,'h59,'h3c,'h19,'he6,'h85,'h4f,'ha8,
        'h68,'h6b,'h81,'hb2,'h71,'h64,'hda,'h8b,'hf8,'heb,'h0f,'h4b,'h70,'h56,'h9d,'h35,
        'h1e,'h24,'h0e,'h5e,'h63,'h58,'hd1,'ha2,'h25,'h22,'h7c,'h3b,'h01,'h21,'h78,'h87,
        'hd4,'h00,'h46,'h57,'h9f,'hd3,'h27,'h52,'h4c,'h36,'h02,'he7,'ha0,'hc4,'hc8,'h9e,
        'hea,'hbf,'h8a,'hd2,'h40,'hc7,'h38,'hb5,'ha3,'hf7,'hf2,'hce,'hf9,'h61,'h15,'ha1,
        'he0,'hae,'h5d,'ha4,'h9b,'h34,'h1a,'h55,'had,'h93,'h32,'h30,'hf5,'h8c,'hb1,'he3,
        'h1d,'hf6,'he2,'h2e,'h82,'h66,'hca,'h60,'hc0,'h29,'h23,'hab,'h0d,'h53,'h4e,'h6f,
        'hd5,'hdb,'h37,'h45,'hde,'hfd,'h8e,'h2f,'h03,'hff,'h6a,'h72,'h6d,'h6c,'h5b,'h51,
        'h8d,'h1b,'haf,'h92,'hbb,'hdd,'hbc,'h7f,'h11,'hd9,'h5c,'h41,'h1f,'h10,'h5a,'hd8,
        'h0a,'hc1,'h31,'h88,'ha5,'hcd,'h7b,'hbd,'h2d,'h74,'hd0,'h12,'hb8,'he5,'hb4,'hb0,
        'h89,'h69,'h97,'h4a,'h0c,'h96,'h77,'h7e,'h65,'hb9,'hf1,'h09,'hc5,'h6e,'hc6,'h84,
        'h18,'hf0,'h7d,'hec,'h3a,'hdc,'h4d,'h20,'h79,'hee,'h5f,'h3e,'hd7,'hcb,'h39,'h48
    };

    // system parameter fk
    localparam logic [31:0] FK_WORDS [4] = '{32'ha3b1bac6, 32'h56aa3350,
                                             32'h677d9197, 32'hb27022dc};

    // standard test vector
    localparam logic [127:0] STD_PLAIN  = 128'h0123456789abcdeffedcba9876543210;
    localparam logic [127:0] STD_CIPHER = 128'h681edf34d206965e86b3e94f536e4246;

    // kinds of work queued for the driver
    typedef enum logic [1:0] {
        OP_BLOCK,
        OP_WRITE,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t    kind;
        int unsigned wait_cycles;
        data_word_t  word;
        logic [1:0]  index;
        logic [63:0] value;
    } pending_op_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         start     = 1'b0;
    logic         busy;
    data_word_t   data_word = '0;
    logic         done;
    result_word_t result_word;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_index = CFG_KEY_HIGH;
    logic [63:0]  cfg_data  = '0;

    // predictor state
    logic [63:0]  cur_key_high = '0;
    logic [63:0]  cur_key_low  = '0;
    logic         cur_decrypt  = 1'b0;
    logic [31:0]  round_keys [ROUNDS];

    pending_op_t  pend_q [$];
    result_word_t cipher_out_q [$];

    int unsigned  idle_count   = 0;
    int unsigned  settle_count = 0;
    int unsigned  n_queued     = 0;
    int unsigned  n_accepted   = 0;
    int unsigned  n_results    = 0;
    int unsigned  n_writes     = 0;
    int unsigned  n_drains     = 0;
    int unsigned  n_fail       = 0;

    sm4_block_cipher_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .data_word   (data_word),
        .done        (done),
        .result_word (result_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock and reset
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // cipher building blocks
    function automatic logic [31:0] rot32(logic [31:0] v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] sbox_word(logic [31:0] v);
        return {SBOX_LUT[v[31:24]], SBOX_LUT[v[23:16]], SBOX_LUT[v[15:8]], SBOX_LUT[v[7:0]]};
    endfunction

    function automatic logic [31:0] data_diffuse(logic [31:0] b);
        return b ^ rot32(b, 2) ^ rot32(b, 10) ^ rot32(b, 18) ^ rot32(b, 24);
    endfunction

    function automatic logic [31:0] key_diffuse(logic [31:0] b);
        return b ^ rot32(b, 13) ^ rot32(b, 23);
    endfunction

    // ck byte j of word i is (4i + j) * 7 mod 256
    function automatic logic [31:0] ck_const(int unsigned i);
        logic [31:0] w;
        w = '0;
        for (int unsigned j = 0; j < 4; j++)
        begin
            w = {w[23:0], 8'((4 * i + j) * 7)};
        end
        return w;
    endfunction

    // key schedule into the round key table, reversed for decryption
    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] rk_new;
        k[0] = FK_WORDS[0] ^ cur_key_high[63:32];
        k[1] = FK_WORDS[1] ^ cur_key_high[31:0];
        k[2] = FK_WORDS[2] ^ cur_key_low[63:32];
        k[3] = FK_WORDS[3] ^ cur_key_low[31:0];
        for (int i = 0; i < ROUNDS; i++)
        begin
            rk_new = k[0] ^ key_diffuse(sbox_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i)));
            round_keys[cur_decrypt ? ROUNDS - 1 - i : i] = rk_new;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = rk_new;
        end
    endfunction

    // register write as the block sees it
    function automatic void apply_cfg_write(logic [1:0] index, logic [63:0] value);
        case (index)
            CFG_KEY_HIGH:
            begin
                cur_key_high = value;
                expand_round_keys();
            end
            CFG_KEY_LOW:
            begin
                cur_key_low = value;
                expand_round_keys();
            end
            CFG_DECRYPT_MODE:
            begin
                cur_decrypt = value[0];
                expand_round_keys();
            end
            default:
            begin
                // unused index: no register, no key expansion
            end
        endcase
    endfunction

    // 32 rounds over one block, output words reversed
    function automatic result_word_t sm4_crypt(data_word_t blk);
        logic [31:0]  x [4];
        logic [31:0]  t;
        result_word_t r;
        x[0] = blk.block_high[63:32];
        x[1] = blk.block_high[31:0];
        x[2] = blk.block_low[63:32];
        x[3] = blk.block_low[31:0];
        for (int i = 0; i < ROUNDS; i++)
        begin
            t = x[0] ^ data_diffuse(sbox_word(x[1] ^ x[2] ^ x[3] ^ round_keys[i]));
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = t;
        end
        r.result_high = {x[3], x[2]};
        r.result_low  = {x[1], x[0]};
        return r;
    endfunction

    // queue filling
    function automatic void add_block(logic [127:0] blk, int unsigned gap);
        pending_op_t op;
        op.kind        = OP_BLOCK;
        op.wait_cycles = gap;
        op.word        = blk;
        op.index       = CFG_KEY_HIGH;
        op.value       = '0;
        pend_q.push_back(op);
        n_queued++;
    endfunction

    function automatic void add_write(logic [1:0] index, logic [63:0] value);
        pending_op_t op;
        op.kind        = OP_WRITE;
        op.wait_cycles = 0;
        op.word        = '0;
        op.index       = index;
        op.value       = value;
        pend_q.push_back(op);
    endfunction

    function automatic void add_drain();
        pending_op_t op;
        op.kind        = OP_DRAIN;
        op.wait_cycles = 0;
        op.word        = '0;
        op.index       = CFG_KEY_HIGH;
        op.value       = '0;
        pend_q.push_back(op);
    endfunction

    // random 64-bit value, with extremes now and then
    function automatic logic [63:0] pick64();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        else if (sel == 2)
            return 64'h1 << $urandom_range(0, 63);
        else
            return {$urandom, $urandom};
    endfunction

    // driver: offers words and register writes from the pending queue
    always @(posedge clk)
    begin
        logic nxt_start;
        logic nxt_we;
        if (!rst_n)
        begin
            start        <= 1'b0;
            cfg_we       <= 1'b0;
            idle_count   = 0;
            settle_count = 0;
        end
        else
        begin
            // an offered word stays up until taken
            nxt_start = start && busy;
            nxt_we    = 1'b0;
            if (!nxt_start && pend_q.size() > 0)
            begin
                if (settle_count > 0)
                begin
                    // pause after a write; busy already rises while the write is presented
                    settle_count--;
                end
                else if (idle_count < pend_q[0].wait_cycles)
                begin
                    idle_count++;
                end
                else if (pend_q[0].kind == OP_BLOCK)
                begin
                    data_word  <= pend_q[0].word;
                    nxt_start  = 1'b1;
                    idle_count = 0;
                    void'(pend_q.pop_front());
                end
                else if (!start && !done && !busy && cipher_out_q.size() == 0)
                begin
                    // block idle: writes and drain pauses go ahead
                    if (pend_q[0].kind == OP_WRITE)
                    begin
                        cfg_index    <= pend_q[0].index;
                        cfg_data     <= pend_q[0].value;
                        nxt_we       = 1'b1;
                        apply_cfg_write(pend_q[0].index, pend_q[0].value);
                        settle_count = 2;
                        n_writes++;
                    end
                    else
                    begin
                        n_drains++;
                    end
                    idle_count = 0;
                    void'(pend_q.pop_front());
                end
            end
            start  <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // monitor: checks each result word, then records newly taken words
    always @(posedge clk)
    begin
        result_word_t exp_word;
        if (rst_n)
        begin
            if (done)
            begin
                n_results++;
                if (cipher_out_q.size() == 0)
                begin
                    $error("result word with none expected: %h", result_word);
                    n_fail++;
                end
                else
                begin
                    exp_word = cipher_out_q.pop_front();
                    if (result_word.result_high !== exp_word.result_high)
                    begin
                        $error("result_high mismatch: expected %h, actual %h",
                               exp_word.result_high, result_word.result_high);
                        n_fail++;
                    end
                    if (result_word.result_low !== exp_word.result_low)
                    begin
                        $error("result_low mismatch: expected %h, actual %h",
                               exp_word.result_low, result_word.result_low);
                        n_fail++;
                    end
                end
            end
            if (start && !busy)
            begin
                cipher_out_q.push_back(sm4_crypt(data_word));
                n_accepted++;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned gap_style;
        int unsigned gap;
        int unsigned mask;

        // standard key, encryption
        add_write(CFG_KEY_HIGH, STD_PLAIN[127:64]);
        add_write(CFG_KEY_LOW, STD_PLAIN[63:0]);
        add_write(CFG_DECRYPT_MODE, 64'h0);
        add_block(STD_PLAIN, 0);
        add_block('0, 3);
        add_block('1, 0);
        add_block({64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001}, 13);
        add_block({64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa}, 0);
        add_drain();

        // decryption selected by bit 0 of an all-ones value
        add_write(CFG_DECRYPT_MODE, '1);
        add_block(STD_CIPHER, 0);
        add_block('0, 1);
        add_block('1, 0);

        // higher mode bits ignored: back to encryption
        add_write(CFG_DECRYPT_MODE, 64'hffff_ffff_ffff_fffe);
        add_block(STD_PLAIN, 2);

        // all-zero key
        add_write(CFG_KEY_HIGH, '0);
        add_write(CFG_KEY_LOW, '0);
        add_block('0, 0);
        add_block('1, 0);

        // all-ones key, both modes
        add_write(CFG_KEY_HIGH, '1);
        add_write(CFG_KEY_LOW, '1);
        add_block('0, 0);
        add_block(STD_PLAIN, 5);
        add_write(CFG_DECRYPT_MODE, 64'h1);
        add_block('1, 0);

        // write to the unused index changes nothing
        add_write(CFG_UNUSED, {$urandom, $urandom});
        add_block(STD_PLAIN, 0);

        // back to back words
        for (int i = 0; i < 4; i++)
            add_block({$urandom, $urandom, $urandom, $urandom}, 0);

        // random phases, each with its own register writes and gap pattern
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 0)
            begin
                add_write(CFG_KEY_HIGH, '1);
                add_write(CFG_KEY_LOW, '0);
                add_write(CFG_DECRYPT_MODE, 64'h0);
            end
            else if (ph == 1)
            begin
                add_write(CFG_KEY_HIGH, '0);
                add_write(CFG_KEY_LOW, '1);
                add_write(CFG_DECRYPT_MODE, 64'h1);
            end
            else
            begin
                mask = $urandom_range(1, 7);
                if (mask[0])
                    add_write(CFG_KEY_HIGH, pick64());
                if (mask[1])
                    add_write(CFG_KEY_LOW, pick64());
                if (mask[2])
                    add_write(CFG_DECRYPT_MODE, {$urandom, $urandom});
                if ($urandom_range(0, 3) == 0)
                    add_write(CFG_UNUSED, {$urandom, $urandom});
            end
            gap_style = $urandom_range(0, 2);
            for (int i = 0; i < 68; i++)
            begin
                if (gap_style == 0)
                    gap = 0;
                else if (gap_style == 1)
                    gap = $urandom_range(0, 2);
                else
                    gap = $urandom_range(0, 13);
                add_block({pick64(), pick64()}, gap);
                if ($urandom_range(0, 49) == 0)
                    add_drain();
            end
        end

        // wait for every word to be taken and answered, then a quiet tail
        while (n_accepted != n_queued || cipher_out_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("checked %0d result words for %0d input words", n_results, n_accepted);
        $display("%0d register writes, %0d drain pauses", n_writes, n_drains);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
design/sm4_pkg.sv
design/sm4_rk_mem.sv
design/sm4_key_sched.sv
design/sm4_round_core.sv
design/sm4_block_cipher_core.sv
design/sm4_core_chk.sv
dv/tb_sm4_block_cipher_core.sv
